/* design/linked_cell_list_builder_macros.svh */
// assertion macros for the linked cell list builder checker
`ifndef LINKED_CELL_LIST_BUILDER_MACROS_SVH
`define LINKED_CELL_LIST_BUILDER_MACROS_SVH

// same-cycle implication, off during reset
`define LCL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("linked cell list check failed");

// next-cycle implication, off during reset
`define LCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("linked cell list check failed");

// what must follow a reset cycle
`define LCL_ASSERT_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("linked cell list check failed");

`endif

/* design/lcl_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the linked cell list builder
package lcl_pkg;

    localparam int DEF_MAX_CELLS = 4096;
    localparam int DEF_MAX_ATOMS = 4096;

    localparam int FIELD_W    = 13;
    localparam int IDX_W      = 17;
    localparam int POS_W      = 24;
    localparam int INV_W      = 24;
    localparam int CNT_W      = 7;
    localparam int PROD_SHIFT = 28;
    localparam int COORD_W    = POS_W + INV_W - PROD_SHIFT;
    localparam int CELL_W     = 15;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_HEAD   = 2'd2,
        CMD_LINK   = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_QUERY = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELLS_X = 2'd0,
        CFG_CELLS_Y = 2'd1,
        CFG_INV_X   = 2'd2,
        CFG_INV_Y   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic accept;
        logic mul;
        logic wrap;
        logic cell_idx;
        logic look;
        logic commit;
        logic sweep;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_command in_cmd;
        logic     out_free;
        logic     sweep_last;
    } t_dp_stat;

endpackage

/* design/lcl_ctrl.sv */
`timescale 1ns / 1ps
// controller state machine for the linked cell list builder
module lcl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_tvalid,
    output logic              o_in_tready,
    input  lcl_pkg::t_dp_stat i_stat,
    output lcl_pkg::t_dp_cmd  o_cmd
);
    import lcl_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_MUL    = 8'b0000_0100,
        S_WRAP   = 8'b0000_1000,
        S_CELL   = 8'b0001_0000,
        S_LOOK   = 8'b0010_0000,
        S_COMMIT = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_sweep_cmd, n_sweep_cmd;

    always_comb begin
        n_state     = r_state;
        n_sweep_cmd = r_sweep_cmd;
        o_cmd       = '0;
        o_in_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state     = r_sweep_cmd ? S_DONE : S_IDLE;
                    n_sweep_cmd = 1'b0;
                end
            end
            S_IDLE: begin
                o_in_tready = 1'b1;
                if (i_in_tvalid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_stat.in_cmd)
                        CMD_CLEAR: begin
                            n_state     = S_CLEAR;
                            n_sweep_cmd = 1'b1;
                        end
                        CMD_INSERT: n_state = S_MUL;
                        CMD_HEAD:   n_state = S_LOOK;
                        CMD_LINK:   n_state = S_LOOK;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_WRAP;
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = S_CELL;
            end
            S_CELL: begin
                o_cmd.cell_idx = 1'b1;
                n_state        = S_LOOK;
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep_cmd <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep_cmd <= n_sweep_cmd;
        end
    end

endmodule

/* design/lcl_datapath.sv */
`timescale 1ns / 1ps
// datapath of the linked cell list builder: config, cell math, memories, output word
module lcl_datapath #(
    parameter int MAX_CELLS = lcl_pkg::DEF_MAX_CELLS,
    parameter int MAX_ATOMS = lcl_pkg::DEF_MAX_ATOMS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lcl_pkg::t_dp_cmd                i_cmd,
    output lcl_pkg::t_dp_stat               o_stat,
    input  logic                            i_cfg_we,
    input  logic [lcl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lcl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [lcl_pkg::IN_DATA_W-1:0]   i_in_tdata,
    input  logic [1:0]                      i_in_tuser,
    output logic                            o_out_tvalid,
    input  logic                            i_out_tready,
    output logic [lcl_pkg::OUT_DATA_W-1:0]  o_out_tdata,
    output logic [1:0]                      o_out_tuser
);
    import lcl_pkg::*;

    localparam int HAW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int LAW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CTW = $clog2(MAX_ATOMS + 1);
    localparam int PW  = POS_W + INV_W;

    // config registers
    logic [CNT_W-1:0] r_cells_x, r_cells_y;
    logic [INV_W-1:0] r_inv_x, r_inv_y;

    // latched input word
    t_command           r_cmd;
    logic [POS_W-1:0]   r_px, r_py;
    logic [FIELD_W-1:0] r_cq, r_aq;

    // cell arithmetic
    logic [COORD_W-1:0] r_cx, r_cy;
    logic [CNT_W-1:0]   r_ix, r_iy;
    logic               r_ok_x, r_ok_y;
    logic [CELL_W-1:0]  r_cell;

    // memories and read data
    logic [FIELD_W-1:0] r_heads [MAX_CELLS];
    logic [FIELD_W-1:0] r_links [MAX_ATOMS];
    logic [FIELD_W-1:0] r_head_rd, r_link_rd;

    logic [CTW-1:0] r_count;
    logic [HAW-1:0] r_sweep;

    // result and output word
    logic [FIELD_W-1:0]    r_res_atom, r_res_cell, r_res_link;
    t_status               r_res_st;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    t_status               r_out_st;

    logic [FIELD_W-1:0] n_res_atom, n_res_cell, n_res_link;
    t_status            n_res_st;

    t_command           in_cmd;
    logic [POS_W-1:0]   in_px, in_py;
    logic [FIELD_W-1:0] in_cq, in_aq;

    logic [PW-1:0]        prod_x, prod_y;
    logic [CNT_W:0]       wrap_x, wrap_y;
    logic [CNT_W-1:0]     stride;
    logic [2*CNT_W-1:0]   iy_off;
    logic [CELL_W-1:0]    n_cell;
    logic [IDX_W-1:0]     cell_m1, cq_m1, aq_m1, head_sel;
    logic [HAW-1:0]       head_ra, head_wa;
    logic [FIELD_W-1:0]   head_wd, atom_field;
    logic                 head_we, link_we;
    logic [CTW-1:0]       atom_next;
    logic                 full, cell_ok, insert_ok, head_q_bad, link_q_bad;

    function automatic logic [CNT_W:0] wrap_coord(input logic [COORD_W-1:0] c,
                                                  input logic [CNT_W-1:0]   n);
        logic [COORD_W-1:0] n_w;
        logic [COORD_W-1:0] c1;
        n_w = COORD_W'(n);
        c1  = (c >= n_w) ? c - n_w : c;
        return {c1 < n_w, c1[CNT_W-1:0]};
    endfunction

    assign in_cmd = t_command'(i_in_tuser);
    assign in_px  = i_in_tdata[23:0];
    assign in_py  = i_in_tdata[47:24];
    assign in_cq  = i_in_tdata[60:48];
    assign in_aq  = i_in_tdata[73:61];

    assign prod_x = PW'(r_px) * PW'(r_inv_x);
    assign prod_y = PW'(r_py) * PW'(r_inv_y);
    assign wrap_x = wrap_coord(r_cx, r_cells_x);
    assign wrap_y = wrap_coord(r_cy, r_cells_y);

    assign stride = (r_cells_x >= r_cells_y) ? r_cells_x : r_cells_y;
    assign iy_off = r_iy * stride;
    assign n_cell = CELL_W'(1) + CELL_W'(r_ix) + CELL_W'(iy_off);

    assign cell_m1  = IDX_W'(r_cell) - IDX_W'(1);
    assign cq_m1    = IDX_W'(r_cq) - IDX_W'(1);
    assign aq_m1    = IDX_W'(r_aq) - IDX_W'(1);
    assign head_sel = (r_cmd == CMD_HEAD) ? cq_m1 : cell_m1;
    assign head_ra  = head_sel[HAW-1:0];

    assign full       = IDX_W'(r_count) >= IDX_W'(MAX_ATOMS);
    assign cell_ok    = r_ok_x && r_ok_y && (IDX_W'(r_cell) <= IDX_W'(MAX_CELLS));
    assign insert_ok  = (r_cmd == CMD_INSERT) && !full && cell_ok;
    assign head_q_bad = (r_cq == '0) || (IDX_W'(r_cq) > IDX_W'(MAX_CELLS));
    assign link_q_bad = (r_aq == '0) || (IDX_W'(r_aq) > IDX_W'(r_count));
    assign atom_next  = r_count + CTW'(1);
    assign atom_field = FIELD_W'(atom_next);

    assign head_we = (i_cmd.commit && insert_ok) || i_cmd.sweep;
    assign head_wa = i_cmd.sweep ? r_sweep : cell_m1[HAW-1:0];
    assign head_wd = i_cmd.sweep ? '0 : atom_field;
    assign link_we = i_cmd.commit && insert_ok;

    always_comb begin
        n_res_atom = '0;
        n_res_cell = '0;
        n_res_link = '0;
        n_res_st   = ST_OK;
        unique case (r_cmd)
            CMD_INSERT: begin
                if (full) begin
                    n_res_st = ST_FULL;
                end else if (!cell_ok) begin
                    n_res_st = ST_RANGE;
                end else begin
                    n_res_atom = atom_field;
                    n_res_cell = FIELD_W'(r_cell);
                    n_res_link = r_head_rd;
                end
            end
            CMD_HEAD: begin
                if (head_q_bad) begin
                    n_res_st = ST_QUERY;
                end else begin
                    n_res_link = r_head_rd;
                end
            end
            CMD_LINK: begin
                if (link_q_bad) begin
                    n_res_st = ST_QUERY;
                end else begin
                    n_res_link = r_link_rd;
                end
            end
            default: n_res_st = ST_OK;
        endcase
    end

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= CNT_W'(64);
            r_cells_y <= CNT_W'(64);
            r_inv_x   <= INV_W'(65536);
            r_inv_y   <= INV_W'(65536);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CELLS_X: r_cells_x <= i_cfg_data[CNT_W-1:0];
                CFG_CELLS_Y: r_cells_y <= i_cfg_data[CNT_W-1:0];
                CFG_INV_X:   r_inv_x   <= i_cfg_data[INV_W-1:0];
                CFG_INV_Y:   r_inv_y   <= i_cfg_data[INV_W-1:0];
                default:     r_inv_y   <= r_inv_y;
            endcase
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd <= in_cmd;
            r_px  <= in_px;
            r_py  <= in_py;
            r_cq  <= in_cq;
            r_aq  <= in_aq;
        end
        if (i_cmd.mul) begin
            r_cx <= prod_x[PW-1:PROD_SHIFT];
            r_cy <= prod_y[PW-1:PROD_SHIFT];
        end
        if (i_cmd.wrap) begin
            r_ok_x <= wrap_x[CNT_W];
            r_ix   <= wrap_x[CNT_W-1:0];
            r_ok_y <= wrap_y[CNT_W];
            r_iy   <= wrap_y[CNT_W-1:0];
        end
        if (i_cmd.cell_idx) begin
            r_cell <= n_cell;
        end
        if (i_cmd.accept && in_cmd == CMD_CLEAR) begin
            r_res_atom <= '0;
            r_res_cell <= '0;
            r_res_link <= '0;
            r_res_st   <= ST_OK;
        end else if (i_cmd.commit) begin
            r_res_atom <= n_res_atom;
            r_res_cell <= n_res_cell;
            r_res_link <= n_res_link;
            r_res_st   <= n_res_st;
        end
    end

    // cell head memory
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_heads[head_wa] <= head_wd;
        end
        if (i_cmd.look) begin
            r_head_rd <= r_heads[head_ra];
        end
    end

    // atom link memory
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_links[r_count[LAW-1:0]] <= r_head_rd;
        end
        if (i_cmd.look) begin
            r_link_rd <= r_links[aq_m1[LAW-1:0]];
        end
    end

    // atom counter and clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sweep <= '0;
        end else begin
            if (i_cmd.accept && in_cmd == CMD_CLEAR) begin
                r_count <= '0;
            end else if (link_we) begin
                r_count <= atom_next;
            end
            if (i_cmd.sweep) begin
                r_sweep <= o_stat.sweep_last ? '0 : r_sweep + HAW'(1);
            end
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_tready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_data <= {1'b0, r_res_link, r_res_cell, r_res_atom};
            r_out_st   <= r_res_st;
        end
    end

    assign o_stat.in_cmd     = in_cmd;
    assign o_stat.out_free   = !r_out_valid || i_out_tready;
    assign o_stat.sweep_last = (r_sweep == HAW'(MAX_CELLS - 1));

    assign o_out_tvalid = r_out_valid;
    assign o_out_tdata  = r_out_data;
    assign o_out_tuser  = r_out_st;

endmodule

/* design/linked_cell_list_builder.sv */
`timescale 1ns / 1ps
// top level of the linked cell list builder
// Usage: command words enter on the s_axis side, one result word per command
// leaves on the m_axis side. tuser in carries the command (clear, insert,
// read cell head, read atom link); tuser out carries the status code.
// The user must set registers cells_x, cells_y, inv_cell_x, inv_cell_y
// through the write port (i_cfg_we, i_cfg_idx, i_cfg_data) while the block
// is idle; the block itself does not enforce this. One command is worked at
// a time by a state machine stepping the datapath. An insert steps through
// multiply, wrap, cell index, head memory read, head/link write and output
// load. Clear runs the head memory sweep of one entry a cycle; after reset
// the same sweep runs with s_axis_tready low.
// The result word sits in an output register; the next command is accepted
// while it waits, and a new result waits in the datapath until the receiver
// takes the old one.
module linked_cell_list_builder #(
    parameter int MAX_CELLS = lcl_pkg::DEF_MAX_CELLS,
    parameter int MAX_ATOMS = lcl_pkg::DEF_MAX_ATOMS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lcl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lcl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pos_x, pos_y, cell_query, atom_query, zero pad
    input  logic [lcl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // command
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // atom_number, cell_number, link, zero pad
    output logic [lcl_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status
    output logic [1:0]                      m_axis_tuser
);
    import lcl_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    lcl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (s_axis_tvalid),
        .o_in_tready (s_axis_tready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    lcl_datapath #(
        .MAX_CELLS (MAX_CELLS),
        .MAX_ATOMS (MAX_ATOMS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .o_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .o_out_tdata  (m_axis_tdata),
        .o_out_tuser  (m_axis_tuser)
    );

endmodule

/* design/lcl_checker.sv */
`timescale 1ns / 1ps
// port checker for the linked cell list builder, bound to the top level
`include "linked_cell_list_builder_macros.svh"

module lcl_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [lcl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]                     m_axis_tuser
);
    import lcl_pkg::*;

    `LCL_ASSERT_RESET(a_sweep_after_reset, i_clk, i_rst_n, !s_axis_tready)
    `LCL_ASSERT_NEXT(a_one_word_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `LCL_ASSERT_NEXT(a_hold_when_stalled, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `LCL_ASSERT_SAME(a_error_word_empty, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata == '0)
    `LCL_ASSERT_SAME(a_atom_has_cell, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[12:0] != '0, m_axis_tdata[25:13] != '0)

endmodule

bind linked_cell_list_builder lcl_checker u_lcl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* bench/linked_cell_list_builder_tb.sv */
`timescale 1ns / 1ps
// testbench for the linked cell list builder: directed and random commands checked against a local model
module linked_cell_list_builder_tb;
    import lcl_pkg::*;

    localparam int N_CELLS = DEF_MAX_CELLS;
    localparam int N_ATOMS = DEF_MAX_ATOMS;

    typedef struct {
        logic [FIELD_W-1:0] atom;
        logic [FIELD_W-1:0] cell_no;
        logic [FIELD_W-1:0] link;
        t_status            status;
    } t_cl_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // pos_x, pos_y, cell_query, atom_query, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // command
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // atom_number, cell_number, link, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // status
    logic [1:0]            m_axis_tuser;

    // model state
    logic [CNT_W-1:0]   cells_x_q = 7'd64;
    logic [CNT_W-1:0]   cells_y_q = 7'd64;
    logic [INV_W-1:0]   inv_x_q = 24'd65536;
    logic [INV_W-1:0]   inv_y_q = 24'd65536;
    logic [FIELD_W-1:0] head_mem [1:N_CELLS];
    logic [FIELD_W-1:0] link_mem [1:N_ATOMS];
    logic [FIELD_W-1:0] atom_total;

    t_cl_result awaited_results[$];
    int err_count = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    linked_cell_list_builder #(
        .MAX_CELLS(N_CELLS),
        .MAX_ATOMS(N_ATOMS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [IN_DATA_W-1:0] make_word(input logic [POS_W-1:0] px,
                                                       input logic [POS_W-1:0] py,
                                                       input logic [FIELD_W-1:0] cq,
                                                       input logic [FIELD_W-1:0] aq);
        return {6'd0, aq, cq, py, px};
    endfunction

    function automatic void empty_cells();
        for (int k = 1; k <= N_CELLS; k++) head_mem[k] = '0;
        atom_total = '0;
    endfunction

    // {in range, coordinate}
    function automatic logic [20:0] wrap_coord(input logic [POS_W-1:0] pos,
                                               input logic [INV_W-1:0] inv,
                                               input logic [CNT_W-1:0] cnt);
        logic [47:0] prod;
        logic [19:0] c;
        prod = {24'd0, pos} * {24'd0, inv};
        c = prod[47:28];
        if (c >= {13'd0, cnt}) c = c - {13'd0, cnt};
        return {c < {13'd0, cnt}, c};
    endfunction

    function automatic t_cl_result apply_command(input t_command cmd,
                                                 input logic [IN_DATA_W-1:0] data);
        t_cl_result         res;
        logic [20:0]        cx;
        logic [20:0]        cy;
        logic [31:0]        stride;
        logic [31:0]        cell_no;
        logic [FIELD_W-1:0] q;
        res.atom = '0;
        res.cell_no = '0;
        res.link = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_CLEAR: begin
                empty_cells();
            end
            CMD_INSERT: begin
                cx = wrap_coord(data[23:0], inv_x_q, cells_x_q);
                cy = wrap_coord(data[47:24], inv_y_q, cells_y_q);
                stride = (cells_x_q >= cells_y_q) ? 32'(cells_x_q) : 32'(cells_y_q);
                cell_no = 32'd1 + 32'(cx[19:0]) + 32'(cy[19:0]) * stride;
                if (atom_total >= N_ATOMS) begin
                    res.status = ST_FULL;
                end else if (!cx[20] || !cy[20] || cell_no > N_CELLS) begin
                    res.status = ST_RANGE;
                end else begin
                    atom_total = atom_total + 1'b1;
                    res.atom = atom_total;
                    res.cell_no = cell_no[FIELD_W-1:0];
                    res.link = head_mem[cell_no];
                    link_mem[atom_total] = head_mem[cell_no];
                    head_mem[cell_no] = atom_total;
                end
            end
            CMD_HEAD: begin
                q = data[60:48];
                if (q == 0 || q > N_CELLS) res.status = ST_QUERY;
                else res.link = head_mem[q];
            end
            default: begin
                q = data[73:61];
                if (q == 0 || q > atom_total) res.status = ST_QUERY;
                else res.link = link_mem[q];
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < 200) $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        err_count++;
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_cl_result want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("word with nothing pending", 0, 0);
            end else begin
                want = awaited_results.pop_front();
                if (m_axis_tdata[12:0] !== want.atom)
                    report_mismatch("atom_number", m_axis_tdata[12:0], want.atom);
                if (m_axis_tdata[25:13] !== want.cell_no)
                    report_mismatch("cell_number", m_axis_tdata[25:13], want.cell_no);
                if (m_axis_tdata[38:26] !== want.link)
                    report_mismatch("link", m_axis_tdata[38:26], want.link);
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", m_axis_tuser, want.status);
            end
        end
        m_axis_tready <= (snk_stall_pct == 0) || ($urandom_range(0, 99) >= snk_stall_pct);
    end

    task automatic send_command(input t_command cmd, input logic [IN_DATA_W-1:0] data);
        while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        awaited_results.push_back(apply_command(cmd, data));
    endtask

    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CNT_W-1:0] cx, input logic [CNT_W-1:0] cy,
                              input logic [INV_W-1:0] ivx, input logic [INV_W-1:0] ivy);
        wait_results();
        put_reg(CFG_CELLS_X, CFG_DATA_W'(cx));
        put_reg(CFG_CELLS_Y, CFG_DATA_W'(cy));
        put_reg(CFG_INV_X, ivx);
        put_reg(CFG_INV_Y, ivy);
        i_cfg_we <= 1'b0;
        cells_x_q = cx;
        cells_y_q = cy;
        inv_x_q = ivx;
        inv_y_q = ivy;
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 66; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 66; end
            default: begin src_idle_pct = 15; snk_stall_pct = 15; end
        endcase
    endtask

    // positions that mostly land within one wrap of the grid
    function automatic logic [POS_W-1:0] pick_pos(input logic [INV_W-1:0] inv,
                                                  input logic [CNT_W-1:0] cnt);
        longint unsigned lim;
        if (inv == 0 || $urandom_range(0, 9) == 0) return POS_W'($urandom);
        lim = (64'(cnt) * 2 + 1) << 28;
        lim = lim / inv;
        if (lim > 64'hFFFFFF) lim = 64'hFFFFFF;
        return POS_W'($urandom_range(0, 32'(lim)));
    endfunction

    function automatic logic [FIELD_W-1:0] pick_cell();
        int k;
        int hi;
        int stride;
        k = $urandom_range(0, 9);
        stride = (cells_x_q >= cells_y_q) ? cells_x_q : cells_y_q;
        hi = N_CELLS;
        if (cells_x_q != 0 && cells_y_q != 0)
            hi = 1 + (cells_x_q - 1) + (cells_y_q - 1) * stride;
        if (hi > N_CELLS) hi = N_CELLS;
        if (k < 5) return FIELD_W'($urandom_range(1, hi));
        if (k < 9) return FIELD_W'($urandom_range(1, N_CELLS));
        return FIELD_W'($urandom);
    endfunction

    task automatic random_command(output t_command cmd, output logic [IN_DATA_W-1:0] data);
        int r;
        r = $urandom_range(0, 999);
        data = IN_DATA_W'({$urandom, $urandom, $urandom});
        data[79:74] = '0;
        if (r < 6) begin
            cmd = CMD_CLEAR;
        end else if (r < 600) begin
            cmd = CMD_INSERT;
            data[23:0] = pick_pos(inv_x_q, cells_x_q);
            data[47:24] = pick_pos(inv_y_q, cells_y_q);
        end else if (r < 800) begin
            cmd = CMD_HEAD;
            data[60:48] = pick_cell();
        end else begin
            cmd = CMD_LINK;
            if (atom_total != 0 && $urandom_range(0, 9) != 0)
                data[73:61] = FIELD_W'($urandom_range(1, atom_total));
        end
    endtask

    task automatic test_directed_defaults();
        set_idle(0);
        send_command(CMD_HEAD, make_word(0, 0, 1, 0));
        send_command(CMD_HEAD, make_word(0, 0, 4096, 0));
        send_command(CMD_HEAD, make_word(0, 0, 0, 0));
        send_command(CMD_HEAD, make_word(0, 0, 4097, 0));
        send_command(CMD_HEAD, make_word(0, 0, 13'h1FFF, 0));
        send_command(CMD_LINK, make_word(0, 0, 0, 1));
        send_command(CMD_LINK, make_word(0, 0, 0, 0));
        send_command(CMD_INSERT, make_word(0, 0, 0, 0));
        send_command(CMD_INSERT, make_word(24'hFFF, 24'hFFF, 0, 0));
        send_command(CMD_INSERT, make_word(24'hFFFFFF, 0, 0, 0));
        send_command(CMD_INSERT, make_word(0, 24'hFFFFFF, 0, 0));
        send_command(CMD_INSERT, make_word(24'h7FFFF, 24'h40000, 0, 0));
        send_command(CMD_INSERT, make_word(24'h80000, 0, 0, 0));
        send_command(CMD_INSERT, make_word(24'h3FFFF, 24'h3FFFF, 0, 0));
        send_command(CMD_HEAD, make_word(0, 0, 1, 0));
        send_command(CMD_HEAD, make_word(0, 0, 4096, 0));
        send_command(CMD_LINK, make_word(0, 0, 0, 2));
        send_command(CMD_LINK, make_word(0, 0, 0, 1));
        send_command(CMD_LINK, make_word(0, 0, 0, 4));
        send_command(CMD_LINK, make_word(0, 0, 0, 5));
        send_command(CMD_LINK, make_word(0, 0, 0, 13'h1FFF));
        send_command(CMD_CLEAR, make_word(24'hFFFFFF, 24'hFFFFFF, 13'h1FFF, 13'h1FFF));
        send_command(CMD_HEAD, make_word(0, 0, 1, 0));
        send_command(CMD_LINK, make_word(0, 0, 0, 1));
        send_command(CMD_INSERT, make_word(24'h10000, 24'h20000, 0, 0));
        wait_results();
    endtask

    task automatic test_config_extremes();
        set_idle(0);
        set_config(1, 1, 24'd65536, 24'd65536);
        send_command(CMD_INSERT, make_word(24'h0800, 24'h1800, 0, 0));
        send_command(CMD_INSERT, make_word(24'h2000, 0, 0, 0));
        set_config(0, 64, 24'd65536, 24'd65536);
        send_command(CMD_INSERT, make_word(0, 0, 0, 0));
        set_config(64, 0, 24'd65536, 24'd65536);
        send_command(CMD_INSERT, make_word(0, 0, 0, 0));
        set_config(100, 100, 24'd65536, 24'd65536);
        send_command(CMD_INSERT, make_word(24'd99 << 12, 24'd99 << 12, 0, 0));
        send_command(CMD_INSERT, make_word(24'd40 << 12, 24'd40 << 12, 0, 0));
        send_command(CMD_INSERT, make_word(24'd150 << 12, 0, 0, 0));
        set_config(64, 64, 0, 0);
        send_command(CMD_INSERT, make_word(24'hFFFFFF, 24'hFFFFFF, 0, 0));
        set_config(64, 64, 24'hFFFFFF, 24'hFFFFFF);
        send_command(CMD_INSERT, make_word(24'h00000F, 24'h00003F, 0, 0));
        send_command(CMD_INSERT, make_word(24'hFFFFFF, 0, 0, 0));
        send_command(CMD_HEAD, make_word(0, 0, 1, 0));
        wait_results();
    endtask

    task automatic test_random();
        t_command             cmd;
        logic [IN_DATA_W-1:0] data;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_config(64, 64, 24'd65536, 24'd65536);
                1: set_config(1, 1, 24'd65536, 24'd65536);
                2: set_config(64, 64, 24'hFFFFFF, 24'hFFFFFF);
                3: set_config(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                              24'($urandom_range(1 << 12, 1 << 20)),
                              24'($urandom_range(1 << 12, 1 << 20)));
                4: set_config(64, 1, 24'($urandom), 24'($urandom_range(1 << 14, 1 << 18)));
                5: set_config(1, 64, 0, 24'($urandom_range(1 << 14, 1 << 18)));
                6: set_config(127, 127, 24'd65536, 24'd65536);
                default: set_config(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                                    24'($urandom), 24'($urandom));
            endcase
            set_idle(p % 4);
            for (int n = 0; n < 215; n++) begin
                random_command(cmd, data);
                send_command(cmd, data);
            end
            wait_results();
        end
    endtask

    initial begin
        empty_cells();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_defaults();
        test_config_extremes();
        test_random();
        wait_results();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* linked_cell_list_builder.f */
+incdir+design
design/lcl_pkg.sv
design/lcl_ctrl.sv
design/lcl_datapath.sv
design/linked_cell_list_builder.sv
design/lcl_checker.sv
bench/linked_cell_list_builder_tb.sv
